@@ hw/rtl/assert_macros.svh @@
// Assertion helpers. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ hw/rtl/dmfc_pkg.sv @@
package dmfc_pkg;

  localparam int TICKS_PER_UNIT = 10;
  localparam int MAX_AMOUNT     = 10;
  localparam int CAP_TICKS      = 30;

  localparam int NUM_OPTIONS = 4;
  localparam int OPT_W       = $clog2(NUM_OPTIONS);
  localparam int AMT_W       = 4;

  // Phase counter must hold the longest timed phase
  localparam int DYE_LIMIT  = TICKS_PER_UNIT * MAX_AMOUNT;
  localparam int TICK_LIMIT = (DYE_LIMIT > CAP_TICKS) ? DYE_LIMIT : CAP_TICKS;
  localparam int TICK_W     = $clog2(TICK_LIMIT + 1);

  localparam logic [OPT_W-1:0] OPT_RED   = OPT_W'(0);
  localparam logic [OPT_W-1:0] OPT_BLUE  = OPT_W'(1);
  localparam logic [OPT_W-1:0] OPT_GREEN = OPT_W'(2);
  localparam logic [OPT_W-1:0] OPT_MIX   = OPT_W'(3);

  typedef struct packed {
    logic start_button;
    logic stop_button;
    logic option_button;
    logic increase_button;
    logic decrease_button;
    logic at_fill_station;
    logic level_low;
    logic at_cap_station;
  } in_item_t;

  typedef struct packed {
    logic             valve_red;
    logic             valve_blue;
    logic             valve_green;
    logic             mixer_on;
    logic             conveyor_on;
    logic             fill_valve_on;
    logic             capper_on;
    logic             running;
    logic [OPT_W-1:0] selected_option;
    logic [AMT_W-1:0] selected_amount;
  } out_item_t;

endpackage

@@ hw/rtl/dmfc_if.sv @@
interface dmfc_sample_if;
  import dmfc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dmfc_result_if;
  import dmfc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/dispense_mix_fill_cap_sequencer.sv @@
// Dye dispense, mix, fill and cap sequencer; one request per tick sample.
// The result is registered on the edge that accepts the request.
// Throughput: 1 request per cycle unless result waits on ready; one result
// register decouples the two sides. Reset (rst, synchronous, active high):
// idle, amounts zero, mix time selected, no result pending.
`include "assert_macros.svh"

module dispense_mix_fill_cap_sequencer (
  input logic           clk,
  input logic           rst,
  dmfc_sample_if.sink   sample,
  dmfc_result_if.source result
);
  import dmfc_pkg::*;

  typedef enum logic [2:0] {
    PH_DISPENSE,
    PH_MIX,
    PH_MOVE_FILL,
    PH_FILL,
    PH_MOVE_CAP,
    PH_CAP
  } phase_t;

  localparam int NUM_PHASES = 6;

  typedef logic [TICK_W-1:0] tick_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic             run_active;
  phase_t           phase;
  tick_t            tick_count;
  logic [AMT_W-1:0] amounts [NUM_OPTIONS];
  logic [OPT_W-1:0] option_index;
  logic             option_seen;
  logic             increase_seen;
  logic             decrease_seen;

  logic             run_active_next;
  phase_t           phase_next;
  tick_t            tick_count_next;
  logic [OPT_W-1:0] option_index_next;
  logic             option_seen_next;
  logic             increase_seen_next;
  logic             decrease_seen_next;
  logic             amount_we;
  logic [AMT_W-1:0] amount_wdata;

  out_item_t        item_next;
  logic             accept;

  // Result register frees up when empty or being drained this cycle
  assign sample.ready = !result.valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  // ---------------------------------------------------------------------------
  // Phase end limits, from the stored amounts (constant multiplies)
  // ---------------------------------------------------------------------------
  logic [AMT_W-1:0] dye_max;
  tick_t            lim_red, lim_blue, lim_green, lim_dye, lim_mix;

  always_comb begin
    dye_max = amounts[OPT_RED];
    if (amounts[OPT_BLUE] > dye_max) begin
      dye_max = amounts[OPT_BLUE];
    end
    if (amounts[OPT_GREEN] > dye_max) begin
      dye_max = amounts[OPT_GREEN];
    end
  end

  assign lim_red   = tick_t'(TICKS_PER_UNIT) * tick_t'(amounts[OPT_RED]);
  assign lim_blue  = tick_t'(TICKS_PER_UNIT) * tick_t'(amounts[OPT_BLUE]);
  assign lim_green = tick_t'(TICKS_PER_UNIT) * tick_t'(amounts[OPT_GREEN]);
  assign lim_dye   = tick_t'(TICKS_PER_UNIT) * tick_t'(dye_max);
  assign lim_mix   = tick_t'(TICKS_PER_UNIT) * tick_t'(amounts[OPT_MIX]);

  // End condition of a phase as seen this tick. Cap never ends here: the
  // end of the cap phase is caught before the chain (cap_end).
  function automatic logic phase_done(phase_t p, tick_t t, in_item_t s);
    logic d;
    case (p)
      PH_DISPENSE:  d = (t >= lim_dye);
      PH_MIX:       d = (t >= lim_mix);
      PH_MOVE_FILL: d = s.at_fill_station;
      PH_FILL:      d = !s.level_low;
      PH_MOVE_CAP:  d = s.at_cap_station;
      default:      d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic phase_t phase_after(phase_t p);
    phase_t n;
    case (p)
      PH_DISPENSE:  n = PH_MIX;
      PH_MIX:       n = PH_MOVE_FILL;
      PH_MOVE_FILL: n = PH_FILL;
      PH_FILL:      n = PH_MOVE_CAP;
      default:      n = PH_CAP;
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Next state and result for the request at the port
  // ---------------------------------------------------------------------------
  logic             stop, start, opt, inc, dec;
  logic             cap_end, resume, do_run;
  phase_t           run_ph;
  tick_t            run_tk;
  logic             opt_edge, inc_act, dec_act;
  logic [OPT_W-1:0] idx_new;
  logic [AMT_W-1:0] amt_sel, amt_inc, amt_dec;

  always_comb begin
    stop  = sample.payload.stop_button;
    start = sample.payload.start_button;
    opt   = sample.payload.option_button;
    inc   = sample.payload.increase_button;
    dec   = sample.payload.decrease_button;

    // Cap phase has run its full length: the run ends this tick, and a held
    // start restarts at once.
    cap_end = run_active && (phase == PH_CAP) && (tick_count >= tick_t'(CAP_TICKS));
    resume  = run_active && !cap_end;
    do_run  = !stop && (resume || start);

    // Pass through every phase whose end already holds; later phases are
    // entered with a cleared counter.
    run_ph = resume ? phase : PH_DISPENSE;
    run_tk = resume ? tick_count : '0;
    for (int i = 0; i < NUM_PHASES - 1; i++) begin
      if (run_ph != PH_CAP && phase_done(run_ph, run_tk, sample.payload)) begin
        run_ph = phase_after(run_ph);
        run_tk = '0;
      end
    end

    // Idle button editing; option first, then increase, then decrease
    opt_edge = opt && !option_seen;
    idx_new  = opt_edge ? option_index + OPT_W'(1) : option_index;
    option_index_next = do_run ? option_index : idx_new;
    amt_sel  = amounts[option_index_next];
    inc_act  = !do_run && inc && !increase_seen && (amt_sel < AMT_W'(MAX_AMOUNT));
    amt_inc  = amt_sel + AMT_W'(inc_act);
    dec_act  = !do_run && dec && !decrease_seen && (amt_inc != '0);
    amt_dec  = amt_inc - AMT_W'(dec_act);

    amount_we    = !do_run;
    amount_wdata = amt_dec;

    option_seen_next   = do_run ? option_seen   : opt;
    increase_seen_next = do_run ? increase_seen : (inc && (increase_seen || inc_act));
    decrease_seen_next = do_run ? decrease_seen : (dec && (decrease_seen || dec_act));

    run_active_next = do_run;
    phase_next      = do_run ? run_ph : PH_DISPENSE;
    if (!do_run) begin
      tick_count_next = '0;
    end else if (run_tk == {TICK_W{1'b1}}) begin
      tick_count_next = run_tk;
    end else begin
      tick_count_next = run_tk + tick_t'(1);
    end

    item_next = '0;
    if (do_run) begin
      case (run_ph)
        PH_DISPENSE: begin
          item_next.valve_red   = (run_tk < lim_red);
          item_next.valve_blue  = (run_tk < lim_blue);
          item_next.valve_green = (run_tk < lim_green);
        end
        PH_MIX:       item_next.mixer_on      = 1'b1;
        PH_MOVE_FILL: item_next.conveyor_on   = 1'b1;
        PH_FILL:      item_next.fill_valve_on = 1'b1;
        PH_MOVE_CAP:  item_next.conveyor_on   = 1'b1;
        default:      item_next.capper_on     = 1'b1;
      endcase
    end
    item_next.running         = do_run;
    item_next.selected_option = option_index_next;
    item_next.selected_amount = amt_dec;
  end

  // ---------------------------------------------------------------------------
  // State and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active    <= 1'b0;
      phase         <= PH_DISPENSE;
      tick_count    <= '0;
      for (int i = 0; i < NUM_OPTIONS; i++) begin
        amounts[i] <= '0;
      end
      option_index  <= OPT_MIX;
      option_seen   <= 1'b0;
      increase_seen <= 1'b0;
      decrease_seen <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (accept) begin
        run_active    <= run_active_next;
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        option_index  <= option_index_next;
        option_seen   <= option_seen_next;
        increase_seen <= increase_seen_next;
        decrease_seen <= decrease_seen_next;
        if (amount_we) begin
          amounts[option_index_next] <= amount_wdata;
        end
        result.payload <= item_next;
        result.valid   <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic       res_dye_on;
  logic [4:0] res_groups;

  assign res_dye_on = result.payload.valve_red | result.payload.valve_blue |
                      result.payload.valve_green;
  assign res_groups = {result.payload.mixer_on, result.payload.conveyor_on,
                       result.payload.fill_valve_on, result.payload.capper_on, res_dye_on};

  `ASSERT_IMPLIES(a_idle_drives_off, result.valid && !result.payload.running, res_groups == '0)
  `ASSERT_IMPLIES(a_one_drive_group, result.valid, $onehot0(res_groups))
  `ASSERT_NEXT(a_result_follows, accept, result.valid && (result.payload.running == run_active))
  `ASSERT_IMPLIES(a_amount_bound, result.valid, result.payload.selected_amount <= AMT_W'(MAX_AMOUNT))

endmodule

@@ bench/dmfc_sequence_monitor.sv @@
`timescale 1ns / 100ps

module dmfc_sequence_monitor (
  input  logic        clk,
  input  logic        rst,
  dmfc_sample_if      sample,
  dmfc_result_if      result,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned results_checked,
  output int unsigned runs_completed,
  output int unsigned runs_stopped
);
  import dmfc_pkg::*;

  typedef enum logic [2:0] {
    STEP_DYE,
    STEP_MIX,
    STEP_TO_FILL,
    STEP_FILL,
    STEP_TO_CAP,
    STEP_CAP
  } seq_step_t;

  logic             run_on;
  seq_step_t        step;
  int unsigned      step_ticks;
  logic [AMT_W-1:0] amount [NUM_OPTIONS];
  logic [OPT_W-1:0] sel;
  logic             opt_held;
  logic             inc_held;
  logic             dec_held;

  out_item_t        expected_outputs [$];

  // One running tick; drives o and returns 0 when the run is over.
  function automatic logic run_tick(input in_item_t s, inout out_item_t o);
    logic        done;
    int unsigned dye_top;
    if (s.stop_button) begin
      runs_stopped++;
      return 1'b0;
    end
    dye_top = amount[OPT_RED];
    if (amount[OPT_BLUE] > dye_top) dye_top = amount[OPT_BLUE];
    if (amount[OPT_GREEN] > dye_top) dye_top = amount[OPT_GREEN];
    // finished phases fall through within the same tick
    for (int guard = 0; guard < 8; guard++) begin
      case (step)
        STEP_DYE:     done = step_ticks >= TICKS_PER_UNIT * dye_top;
        STEP_MIX:     done = step_ticks >= TICKS_PER_UNIT * amount[OPT_MIX];
        STEP_TO_FILL: done = s.at_fill_station;
        STEP_FILL:    done = !s.level_low;
        STEP_TO_CAP:  done = s.at_cap_station;
        default:      done = step_ticks >= CAP_TICKS;
      endcase
      if (done) begin
        if (step == STEP_CAP) begin
          runs_completed++;
          return 1'b0;
        end
        step       = seq_step_t'(step + 1);
        step_ticks = 0;
      end else begin
        case (step)
          STEP_DYE: begin
            o.valve_red   = step_ticks < TICKS_PER_UNIT * amount[OPT_RED];
            o.valve_blue  = step_ticks < TICKS_PER_UNIT * amount[OPT_BLUE];
            o.valve_green = step_ticks < TICKS_PER_UNIT * amount[OPT_GREEN];
          end
          STEP_MIX:                  o.mixer_on      = 1'b1;
          STEP_TO_FILL, STEP_TO_CAP: o.conveyor_on   = 1'b1;
          STEP_FILL:                 o.fill_valve_on = 1'b1;
          default:                   o.capper_on     = 1'b1;
        endcase
        step_ticks++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Button editing while idle; option is handled first.
  function automatic void edit_amounts(input in_item_t s);
    if (s.option_button && !opt_held) begin
      opt_held = 1'b1;
      sel      = sel + 1'b1;
    end
    if (!s.option_button) opt_held = 1'b0;
    if (s.increase_button && !inc_held && amount[sel] < MAX_AMOUNT) begin
      inc_held    = 1'b1;
      amount[sel] = amount[sel] + 1'b1;
    end
    if (!s.increase_button) inc_held = 1'b0;
    if (s.decrease_button && !dec_held && amount[sel] > 0) begin
      dec_held    = 1'b1;
      amount[sel] = amount[sel] - 1'b1;
    end
    if (!s.decrease_button) dec_held = 1'b0;
  endfunction

  function automatic out_item_t predict_tick(input in_item_t s);
    out_item_t o;
    o = '0;
    if (run_on) begin
      run_on = run_tick(s, o);
      if (!run_on) o = '0;
    end
    // stop while running still gets the idle handling of the same tick
    if (!run_on) begin
      if (s.stop_button) begin
        edit_amounts(s);
      end else if (s.start_button) begin
        run_on     = 1'b1;
        step       = STEP_DYE;
        step_ticks = 0;
        run_on     = run_tick(s, o);
        if (!run_on) o = '0;
      end else begin
        edit_amounts(s);
      end
    end
    o.running         = run_on;
    o.selected_option = sel;
    o.selected_amount = amount[sel];
    return o;
  endfunction

  function automatic void compare_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      run_on     = 1'b0;
      step       = STEP_DYE;
      step_ticks = 0;
      foreach (amount[i]) amount[i] = '0;
      sel      = OPT_MIX;
      opt_held = 1'b0;
      inc_held = 1'b0;
      dec_held = 1'b0;
      expected_outputs.delete();
      mismatches      = 0;
      results_checked = 0;
      runs_completed  = 0;
      runs_stopped    = 0;
    end else begin
      if (result.valid && result.ready) begin
        results_checked++;
        if (expected_outputs.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding: %p", result.payload);
        end else begin
          want = expected_outputs.pop_front();
          compare_field("valve_red", want.valve_red, result.payload.valve_red);
          compare_field("valve_blue", want.valve_blue, result.payload.valve_blue);
          compare_field("valve_green", want.valve_green, result.payload.valve_green);
          compare_field("mixer_on", want.mixer_on, result.payload.mixer_on);
          compare_field("conveyor_on", want.conveyor_on, result.payload.conveyor_on);
          compare_field("fill_valve_on", want.fill_valve_on, result.payload.fill_valve_on);
          compare_field("capper_on", want.capper_on, result.payload.capper_on);
          compare_field("running", want.running, result.payload.running);
          compare_field("selected_option", want.selected_option,
                        result.payload.selected_option);
          compare_field("selected_amount", want.selected_amount,
                        result.payload.selected_amount);
        end
      end
      if (sample.valid && sample.ready)
        expected_outputs.push_back(predict_tick(sample.payload));
    end
    pending <= expected_outputs.size();
  end

endmodule

@@ bench/dispense_mix_fill_cap_sequencer_tb.sv @@
`timescale 1ns / 100ps

module dispense_mix_fill_cap_sequencer_tb;
  import dmfc_pkg::*;

  // Random part stops once this many requests have gone in after the directed part.
  localparam int RANDOM_REQUESTS = 600;

  logic clk;
  logic rst;

  dmfc_sample_if sample_ch ();
  dmfc_result_if result_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned runs_completed;
  int unsigned runs_stopped;

  int unsigned sent;        // requests accepted so far
  int unsigned burst_left;  // requests left in the current sender burst
  logic        steady;      // sender runs without gaps for a while
  int unsigned rx_cycle;

  dispense_mix_fill_cap_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  // Watches both channels, predicts every tick and compares.
  dmfc_sequence_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample_ch),
    .result          (result_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .runs_completed  (runs_completed),
    .runs_stopped    (runs_stopped)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stall pattern rotates through four modes in turn - always ready,
  // random, a short periodic stall and a long periodic stall.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 200) % 4)
      0:       result_ch.ready <= 1'b1;
      1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       result_ch.ready <= ((rx_cycle % 7) < 4);
      default: result_ch.ready <= ((rx_cycle % 40) < 28);
    endcase
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t tick_of(input bit st, sp, op, inc, dec, fill, low, cap);
    return in_item_t'({st, sp, op, inc, dec, fill, low, cap});
  endfunction

  // Hands one tick sample over; valid stays high across a burst and only
  // drops for the gap between bursts. Returns on the accepting edge.
  task automatic send_request(input in_item_t t);
    int unsigned gap;
    if (sent % 150 == 0) steady = ($urandom_range(0, 3) == 0);
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= t;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Sender holds off until every outstanding request has its result.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Press/release pairs; decrease is favoured so amounts stay mostly small
  // and runs stay short.
  task automatic press_buttons(input int unsigned presses);
    int unsigned pick;
    repeat (presses) begin
      pick = $urandom_range(0, 6);
      send_request(tick_of(0, $urandom_range(0, 9) == 0, pick < 2, pick == 2 || pick == 3,
                           pick >= 4, $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1)));
      // release, with some buttons left held now and then
      send_request(tick_of(0, 0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                           $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1)));
    end
  endtask

  // Start tick then a stretch of run ticks with plausible sensor behaviour;
  // start is sometimes still held at the end of the run to force a restart.
  task automatic run_sequence(input int unsigned ticks, input bit may_stop);
    int unsigned stop_at;
    stop_at = may_stop ? $urandom_range(1, ticks) : ticks + 1;
    send_request(tick_of(1, 0, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 5) == 0,
                         $urandom_range(0, 3) != 0, $urandom_range(0, 5) == 0));
    for (int unsigned k = 1; k <= ticks; k++)
      send_request(tick_of($urandom_range(0, 7) == 0, k == stop_at,
                           $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                           $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0,
                           $urandom_range(0, 3) != 0, $urandom_range(0, 5) == 0));
  endtask

  // Drives every amount to the ceiling or the floor, one past the limit.
  task automatic set_all_amounts(input bit up);
    repeat (NUM_OPTIONS) begin
      send_request(tick_of(0, 0, 1, 0, 0, 0, 1, 0));
      repeat (MAX_AMOUNT + 1) begin
        send_request(tick_of(0, 0, 0, up, !up, 0, 1, 0));
        send_request(tick_of(0, 0, 0, 0, 0, 0, 1, 0));
      end
    end
  endtask

  initial begin
    int unsigned directed;
    int unsigned pick;
    bit          max_done;

    rst               <= 1'b1;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    sent       = 0;
    burst_left = 0;
    steady     = 1'b1;
    max_done   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // fields: start, stop, option, increase, decrease, at_fill, level_low, at_cap
    send_request(tick_of(0, 0, 0, 0, 0, 0, 0, 0));  // idle, mix time selected
    send_request(tick_of(0, 0, 0, 0, 1, 0, 1, 0));  // decrease at the floor
    send_request(tick_of(0, 0, 0, 1, 1, 0, 1, 0));  // increase then decrease, same tick
    send_request(tick_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(tick_of(1, 1, 1, 1, 1, 1, 1, 1));  // stop blocks start, edits still apply
    send_request(tick_of(0, 0, 0, 0, 0, 0, 0, 0));
    // zero amounts and sensors already met: every phase but capping passes through
    send_request(tick_of(1, 0, 0, 0, 0, 1, 0, 1));
    send_request(tick_of(0, 0, 1, 0, 0, 0, 1, 0));  // buttons ignored while capping
    send_request(tick_of(0, 1, 1, 0, 0, 0, 1, 0));  // stop aborts; option acts same tick
    send_request(tick_of(0, 0, 0, 0, 0, 0, 1, 0));
    send_request(tick_of(0, 0, 0, 1, 0, 0, 1, 0));
    send_request(tick_of(0, 0, 1, 1, 0, 0, 1, 0));  // option edge, increase still held
    send_request(tick_of(0, 0, 0, 0, 0, 0, 1, 0));
    send_request(tick_of(0, 0, 1, 1, 0, 0, 1, 0));  // option and increase together
    send_request(tick_of(0, 0, 0, 0, 0, 0, 1, 0));
    send_request(tick_of(1, 0, 0, 0, 0, 0, 1, 0));  // start with one dye set
    directed = sent;

    // ---- random ----
    while (sent < directed + RANDOM_REQUESTS) begin
      if (!max_done && sent >= directed + RANDOM_REQUESTS / 8) begin
        // one run at the largest amounts, then back down to the floor
        send_request(tick_of(0, 1, 0, 0, 0, 0, 1, 0));
        send_request(tick_of(0, 0, 0, 0, 0, 0, 1, 0));
        wait_drained();
        set_all_amounts(1'b1);
        run_sequence(2 * TICKS_PER_UNIT * MAX_AMOUNT + CAP_TICKS + 40, 1'b0);
        send_request(tick_of(0, 1, 0, 0, 0, 0, 1, 0));
        set_all_amounts(1'b0);
        max_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 8)
        press_buttons($urandom_range(2, 8));
      else if (pick < 16)
        run_sequence($urandom_range(20, 90), $urandom_range(0, 3) == 0);
      else if (pick < 19)
        repeat ($urandom_range(1, 8)) send_request(in_item_t'(8'($urandom_range(0, 255))));
      else
        wait_drained();
    end

    // ---- wind down ----
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d tick samples, checked %0d results", sent, results_checked);
    $display("Runs: %0d capped to the end, %0d aborted by stop", runs_completed,
             runs_stopped);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dmfc_pkg.sv
hw/rtl/dmfc_if.sv
hw/rtl/dispense_mix_fill_cap_sequencer.sv
bench/dmfc_sequence_monitor.sv
bench/dispense_mix_fill_cap_sequencer_tb.sv
